>>> sv/periodic_timer_table_defines.svh
// Assertion macros shared by the periodic timer table RTL.
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PTT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("periodic_timer_table: check failed");
// Condition that must never be true.
`define PTT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`PTT_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define PTT_ASSERT(lbl, clk, rst_n, prop)
`define PTT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/ptt_pkg.sv
// Types and constants of the periodic timer table.
`timescale 1ns / 1ps
package ptt_pkg;

	// Operation codes of an input word
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_ENABLE   = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_IDLE  = 2'd2;

	// At most this many fired ids are reported per tick
	localparam int MAX_RESULTS = 10;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] timer_id;
		logic [31:0] period;
		logic        enable_flag;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] fired_id;
		logic        status;
		logic        last;
	} out_word_t;

	// Command token that walks down the cell chain
	typedef struct packed {
		logic        valid;
		logic [1:0]  operation;
		logic [15:0] timer_id;
		logic [31:0] period;
		logic        enable_flag;
		logic        found;     // an earlier cell already took the command
		logic        fired;     // this cell fired on the tick
		logic [15:0] fired_id;
	} token_t;

endpackage

>>> sv/ptt_cell.sv
// One timer slot: holds its state and passes the command token on.
`timescale 1ns / 1ps
module ptt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ptt_pkg::token_t tin,
	output ptt_pkg::token_t tout
);

	logic [15:0]     id_q;
	logic [31:0]     period_q;
	logic [31:0]     count_q;
	logic            en_q;
	ptt_pkg::token_t tout_q;

	logic            qualify;
	logic            hit;
	logic            fire;
	ptt_pkg::token_t tnext;

	// slot match and fire decision
	always_comb begin
		qualify = (id_q == 16'd0) || (id_q == tin.timer_id);
		hit     = tin.valid && !tin.found && qualify;
		fire    = (id_q != 16'd0) && en_q && (period_q <= count_q);
		tnext          = tin;
		tnext.found    = tin.found || qualify;
		tnext.fired    = 1'b0;
		tnext.fired_id = 16'd0;
		if (tin.valid && tin.operation == ptt_pkg::OP_TICK && fire) begin
			tnext.fired    = 1'b1;
			tnext.fired_id = id_q;
		end
	end

	// slot state and token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q     <= 16'd0;
			period_q <= 32'd0;
			count_q  <= 32'd0;
			en_q     <= 1'b0;
			tout_q   <= '0;
		end else begin
			tout_q <= tnext;
			if (tin.valid) begin
				unique case (tin.operation)
					ptt_pkg::OP_REGISTER: begin
						if (hit) begin
							id_q     <= tin.timer_id;
							period_q <= tin.period;
							count_q  <= 32'd0;
							en_q     <= 1'b1;
						end
					end
					ptt_pkg::OP_ENABLE: begin
						if (hit) begin
							en_q <= tin.enable_flag;
						end
					end
					ptt_pkg::OP_TICK: begin
						if (fire) begin
							count_q <= 32'd0;
						end else if (count_q != 32'hFFFF_FFFF) begin
							count_q <= count_q + 32'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign tout = tout_q;

endmodule

>>> sv/periodic_timer_table.sv
// Top level of the periodic timer table: entry register, cell chain, result sequencing.
// Usage:
//   An input word on item is taken at a rising edge with start high and busy low.
//   Operations: register a timer, set a timer's enable, or a one millisecond tick.
//   The word enters a chain of SLOTS cells, one slot per cell, and moves one
//   cell per cycle; each cell updates its own slot as the word passes.
//   Results come out on result, one per cycle while strobe is high. Register and
//   enable give one acknowledge word; a tick gives one word per fired timer in
//   slot order (at most ten) or a single idle word. The final word has last set.
//   The final word comes after the entry register, the SLOTS cell registers, fin_q
//   and the result register; busy drops in that same cycle and the next word is
//   taken at the edge that ends it, so no new item is taken before the last is done.
//   Each fired word is held back until the next fire or the final word, so
//   fired words can have idle cycles between them.
//   The receiver cannot stall: every strobed word must be taken when shown.
//   Reset empties every slot, clears all counts and enables, and drops busy.
`timescale 1ns / 1ps
`include "periodic_timer_table_defines.svh"
module periodic_timer_table #(
	parameter int SLOTS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ptt_pkg::in_word_t  item,
	output logic               strobe,
	output ptt_pkg::out_word_t result
);

	logic                      busy_q;
	logic                      accept;
	ptt_pkg::token_t           ent_q;
	ptt_pkg::token_t           tok [SLOTS];
	logic [SLOTS-1:0]          tok_valid;

	logic                      pend_v_q;
	logic [15:0]               pend_id_q;
	logic [ptt_pkg::CNT_W-1:0] n_q;
	logic                      fin_q;
	logic [1:0]                fin_op_q;
	logic                      fin_found_q;
	logic                      strobe_q;
	ptt_pkg::out_word_t        res_q;

	logic                      fire_any;
	logic [15:0]               fire_id;

	assign accept = start && !busy_q;

	// cell chain
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_first
			ptt_cell u_cell (.clk(clk), .arst_n(arst_n), .tin(ent_q), .tout(tok[i]));
		end else begin : g_next
			ptt_cell u_cell (.clk(clk), .arst_n(arst_n), .tin(tok[i-1]), .tout(tok[i]));
		end
		assign tok_valid[i] = tok[i].valid;
	end

	// collect the fire of whichever cell holds the token
	always_comb begin
		fire_any = 1'b0;
		fire_id  = 16'd0;
		for (int i = 0; i < SLOTS; i++) begin
			fire_any = fire_any | (tok[i].valid & tok[i].fired);
			fire_id  = fire_id | (tok[i].valid ? tok[i].fired_id : 16'd0);
		end
	end

	// entry, pending fire and result sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ent_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_id_q   <= 16'd0;
			n_q         <= '0;
			fin_q       <= 1'b0;
			fin_op_q    <= ptt_pkg::OP_REGISTER;
			fin_found_q <= 1'b0;
			strobe_q    <= 1'b0;
			res_q       <= '0;
		end else begin
			ent_q.valid       <= accept;
			ent_q.operation   <= item.operation;
			ent_q.timer_id    <= item.timer_id;
			ent_q.period      <= item.period;
			ent_q.enable_flag <= item.enable_flag;
			ent_q.found       <= 1'b0;
			ent_q.fired       <= 1'b0;
			ent_q.fired_id    <= 16'd0;
			strobe_q          <= 1'b0;

			if (accept) begin
				busy_q   <= 1'b1;
				pend_v_q <= 1'b0;
				n_q      <= '0;
			end

			// hold each fire back until the next one so the final one can carry last
			if (fire_any && (n_q < ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS))) begin
				n_q       <= n_q + ptt_pkg::CNT_W'(1);
				pend_v_q  <= 1'b1;
				pend_id_q <= fire_id;
				if (pend_v_q) begin
					strobe_q <= 1'b1;
					res_q    <= '{result_kind: ptt_pkg::KIND_FIRED, fired_id: pend_id_q,
						status: 1'b0, last: 1'b0};
				end
			end

			fin_q       <= tok[SLOTS-1].valid;
			fin_op_q    <= tok[SLOTS-1].operation;
			fin_found_q <= tok[SLOTS-1].found;

			// final word of the item
			if (fin_q) begin
				busy_q   <= 1'b0;
				pend_v_q <= 1'b0;
				strobe_q <= 1'b1;
				if (fin_op_q == ptt_pkg::OP_TICK) begin
					if (pend_v_q) begin
						res_q <= '{result_kind: ptt_pkg::KIND_FIRED, fired_id: pend_id_q,
							status: 1'b0, last: 1'b1};
					end else begin
						res_q <= '{result_kind: ptt_pkg::KIND_IDLE, fired_id: 16'd0,
							status: 1'b0, last: 1'b1};
					end
				end else begin
					res_q <= '{result_kind: ptt_pkg::KIND_ACK, fired_id: 16'd0,
						status: (fin_op_q == ptt_pkg::OP_REGISTER) && !fin_found_q,
						last: 1'b1};
				end
			end
		end
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = res_q;

	// checks
	`PTT_ASSERT(a_one_token, clk, arst_n, $onehot0(tok_valid))
	`PTT_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy_q)
	`PTT_ASSERT(a_fin_final, clk, arst_n, fin_q |=> (strobe_q && res_q.last))
	`PTT_ASSERT(a_ack_last, clk, arst_n, (strobe_q && res_q.result_kind == ptt_pkg::KIND_ACK) |-> res_q.last)
	`PTT_ASSERT_NEVER(a_pend_idle, clk, arst_n, pend_v_q && !busy_q)

endmodule
